FILE: src/srsw_pkg.sv
// Package for the selective-repeat sender window block.
// Holds beat types, action and state codes, and the default parameter values.
// No dependencies.
package srsw_pkg;

    localparam int SEQ_W        = 3;
    localparam int ACT_W        = 2;
    localparam int PAY_W        = 64;
    localparam int DEF_SEQ_BITS = 3;
    localparam int DEF_WINDOW   = 4;

    typedef enum logic [ACT_W-1:0] {
        ACT_SEND = 2'd0,
        ACT_ACK  = 2'd1,
        ACT_TMO  = 2'd2,
        ACT_RSVD = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEND_FULL,
        ST_SLIDE,
        ST_WIN,
        ST_READ,
        ST_FIN
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic eq;
        logic in_win;
    } t_alu_flags;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [SEQ_W-1:0] seq_num;
        logic             checksum_ok;
        logic [PAY_W-1:0] payload;
    } t_in_beat;

    typedef struct packed {
        logic             accepted;
        logic             tx_valid;
        logic [SEQ_W-1:0] tx_seq;
        logic [PAY_W-1:0] tx_payload;
        logic             timer_start;
        logic             timer_stop;
        logic [SEQ_W-1:0] timer_seq;
        logic             window_full;
        logic [SEQ_W-1:0] window_base;
    } t_out_beat;

endpackage

FILE: src/selective_repeat_sender_window_core.sv
// An accepted send or a timeout goes from EXEC through SEND_FULL or READ to FIN;
// a refused send, a dropped acknowledgement or a reserved action goes from EXEC to
// FIN; an accepted acknowledgement stays in SLIDE while the base slides over k
// numbers (k up to WINDOW), then passes WIN. The sequencer holds one item at a time.
// Synchronous reset clears the window, the full flag and all acked marks at once;
// the packet store is not cleared.
module selective_repeat_sender_window_core #(
    parameter int SEQ_BITS = srsw_pkg::DEF_SEQ_BITS,
    parameter int WINDOW   = srsw_pkg::DEF_WINDOW
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  srsw_pkg::t_in_beat  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output srsw_pkg::t_out_beat o_data
);
    import srsw_pkg::*;

    localparam int SPACE = 1 << SEQ_BITS;
    localparam logic [SEQ_BITS-1:0] WIN_MOD = SEQ_BITS'(WINDOW % SPACE);
    localparam logic [SEQ_BITS-1:0] ONE     = SEQ_BITS'(1);

    t_state              r_state, n_state;
    logic [SEQ_BITS-1:0] r_base, n_base;
    logic [SEQ_BITS-1:0] r_next, n_next;
    logic                r_full, n_full;
    logic [SPACE-1:0]    r_marks, n_marks;
    logic                r_out_valid, n_out_valid;
    t_in_beat            r_in, n_in;
    t_out_beat           r_res, n_res;
    t_out_beat           r_out, n_out;

    t_alu_op             w_op;
    logic [SEQ_BITS-1:0] w_a, w_b, w_cmp, w_res;
    t_alu_flags          w_flags;
    logic [SEQ_BITS-1:0] w_num;
    logic                w_we, w_re;
    logic [PAY_W-1:0]    w_rdata;

    assign w_num = SEQ_BITS'(r_in.seq_num);

    srsw_alu #(
        .SEQ_BITS(SEQ_BITS),
        .WINDOW  (WINDOW)
    ) u_alu (
        .i_op   (w_op),
        .i_a    (w_a),
        .i_b    (w_b),
        .i_cmp  (w_cmp),
        .o_res  (w_res),
        .o_flags(w_flags)
    );

    srsw_ram #(
        .WIDTH(PAY_W),
        .DEPTH(SPACE)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_next),
        .i_wdata(r_in.payload),
        .i_re   (w_re),
        .i_raddr(w_num),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_next      = r_next;
        n_full      = r_full;
        n_marks     = r_marks;
        n_out_valid = r_out_valid;
        n_in        = r_in;
        n_res       = r_res;
        n_out       = r_out;
        w_op        = ALU_ADD;
        w_a         = r_base;
        w_b         = WIN_MOD;
        w_cmp       = r_next;
        w_we        = 1'b0;
        w_re        = 1'b0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_in    = i_data;
                    n_res   = '0;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_FIN;
                case (r_in.action)
                    ACT_SEND: begin
                        w_a = r_next;
                        w_b = ONE;
                        if (!r_full) begin
                            w_we              = 1'b1;
                            n_next            = w_res;
                            n_res.accepted    = 1'b1;
                            n_res.tx_valid    = 1'b1;
                            n_res.tx_seq      = SEQ_W'(r_next);
                            n_res.tx_payload  = r_in.payload;
                            n_res.timer_start = 1'b1;
                            n_res.timer_seq   = SEQ_W'(r_next);
                            n_state           = ST_SEND_FULL;
                        end
                    end
                    ACT_ACK: begin
                        w_op = ALU_SUB;
                        w_a  = w_num;
                        w_b  = r_base;
                        if (r_in.checksum_ok && w_flags.in_win) begin
                            n_marks[w_num]   = 1'b1;
                            n_res.accepted   = 1'b1;
                            n_res.timer_stop = 1'b1;
                            n_res.timer_seq  = SEQ_W'(w_num);
                            n_state          = ST_SLIDE;
                        end
                    end
                    ACT_TMO: begin
                        w_re              = 1'b1;
                        n_res.tx_valid    = 1'b1;
                        n_res.tx_seq      = SEQ_W'(w_num);
                        n_res.timer_start = 1'b1;
                        n_res.timer_seq   = SEQ_W'(w_num);
                        n_state           = ST_READ;
                    end
                    default: begin
                        n_state = ST_FIN;
                    end
                endcase
            end
            ST_SEND_FULL: begin
                if (w_flags.eq) begin
                    n_full = 1'b1;
                end
                n_state = ST_FIN;
            end
            ST_SLIDE: begin
                w_b = ONE;
                if ((r_base != r_next) && r_marks[r_base]) begin
                    n_marks[r_base] = 1'b0;
                    n_base          = w_res;
                end else begin
                    n_state = ST_WIN;
                end
            end
            ST_WIN: begin
                if (!w_flags.eq) begin
                    n_full = 1'b0;
                end
                n_state = ST_FIN;
            end
            ST_READ: begin
                n_res.tx_payload = w_rdata;
                n_state          = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out             = r_res;
                    n_out.window_full = r_full;
                    n_out.window_base = SEQ_W'(r_base);
                    n_out_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_base      <= '0;
            r_next      <= '0;
            r_full      <= 1'b0;
            r_marks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_next      <= n_next;
            r_full      <= n_full;
            r_marks     <= n_marks;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: src/srsw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the packet store. Depends on nothing.
module srsw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/srsw_alu.sv
// Shared modular adder and comparator for sequence-number arithmetic.
// Depends on srsw_pkg for the operation code and flag types.
module srsw_alu #(
    parameter int SEQ_BITS = srsw_pkg::DEF_SEQ_BITS,
    parameter int WINDOW   = srsw_pkg::DEF_WINDOW
) (
    input  srsw_pkg::t_alu_op    i_op,
    input  logic [SEQ_BITS-1:0]  i_a,
    input  logic [SEQ_BITS-1:0]  i_b,
    input  logic [SEQ_BITS-1:0]  i_cmp,
    output logic [SEQ_BITS-1:0]  o_res,
    output srsw_pkg::t_alu_flags o_flags
);
    import srsw_pkg::*;

    always_comb begin
        if (i_op == ALU_SUB) begin
            o_res = i_a - i_b;
        end else begin
            o_res = i_a + i_b;
        end
        o_flags.eq     = (o_res == i_cmp);
        o_flags.in_win = (32'(o_res) < WINDOW);
    end

endmodule

FILE: verif/selective_repeat_sender_window_core_test.sv
// Self-checking testbench for selective_repeat_sender_window_core.
// Directed and random send, acknowledgement and timeout beats are checked against a
// cycle-free model of the sender window. Depends on srsw_pkg and the core itself.
`timescale 1ns / 1ps

module selective_repeat_sender_window_core_test;

    import srsw_pkg::*;

    localparam int SEQ_SPACE    = 1 << DEF_SEQ_BITS;
    localparam int WIN          = DEF_WINDOW;
    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 250;
    localparam int TAIL_CYCLES  = 2 * (5 + DEF_WINDOW);
    localparam longint WATCHDOG_NS = 64'd8_000_000;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_beat  i_data  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_beat o_data;

    logic [SEQ_W-1:0] win_base = '0;
    logic [SEQ_W-1:0] win_next = '0;
    logic             win_full = 1'b0;
    bit               acked [SEQ_SPACE];
    logic [PAY_W-1:0] stored_payload [SEQ_SPACE];
    bit               stored_valid [SEQ_SPACE];

    t_out_beat pending_responses [$];
    int        mismatch_count = 0;
    bit        tx_idle_on = 1'b1;
    logic      rx_idle_on = 1'b1;
    logic      rx_holding = 1'b0;
    int        rx_gap = 0;

    selective_repeat_sender_window_core #(
        .SEQ_BITS(DEF_SEQ_BITS),
        .WINDOW  (DEF_WINDOW)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [SEQ_W-1:0] window_end();
        return win_base + SEQ_W'(WIN);
    endfunction

    function automatic t_out_beat window_response(input t_in_beat beat);
        t_out_beat        r;
        logic [SEQ_W-1:0] num;
        logic [SEQ_W-1:0] off;
        int               k;
        r   = '0;
        num = beat.seq_num;
        case (beat.action)
            ACT_SEND: begin
                if (!win_full) begin
                    stored_payload[win_next] = beat.payload;
                    stored_valid[win_next]   = 1'b1;
                    r.accepted    = 1'b1;
                    r.tx_valid    = 1'b1;
                    r.tx_seq      = win_next;
                    r.tx_payload  = beat.payload;
                    r.timer_start = 1'b1;
                    r.timer_seq   = win_next;
                    win_next      = win_next + 1'b1;
                    if (window_end() == win_next) win_full = 1'b1;
                end
            end
            ACT_ACK: begin
                off = num - win_base;
                if (beat.checksum_ok && off < WIN) begin
                    acked[num] = 1'b1;
                    for (k = 0; k < SEQ_SPACE && win_base != win_next && acked[win_base];
                         k++) begin
                        acked[win_base] = 1'b0;
                        win_base        = win_base + 1'b1;
                    end
                    if (window_end() != win_next) win_full = 1'b0;
                    r.accepted   = 1'b1;
                    r.timer_stop = 1'b1;
                    r.timer_seq  = num;
                end
            end
            ACT_TMO: begin
                r.tx_valid    = 1'b1;
                r.tx_seq      = num;
                r.tx_payload  = stored_payload[num];
                r.timer_start = 1'b1;
                r.timer_seq   = num;
            end
            default: begin
            end
        endcase
        r.window_full = win_full;
        r.window_base = win_base;
        return r;
    endfunction

    function automatic t_in_beat draw_window_item();
        t_in_beat beat;
        int       pick;
        int       span;
        int       k;
        beat.payload     = {$urandom, $urandom};
        beat.seq_num     = SEQ_W'($urandom_range(0, SEQ_SPACE - 1));
        beat.checksum_ok = 1'b1;
        beat.action      = ACT_SEND;
        span = (win_next - win_base) & (SEQ_SPACE - 1);
        pick = $urandom_range(0, 99);
        if (pick < 45 && !win_full) begin
            beat.action = ACT_SEND;
        end else if (pick < 75) begin
            beat.action = ACT_ACK;
            if (span != 0 && $urandom_range(0, 3) != 0) begin
                beat.seq_num = win_base + SEQ_W'($urandom_range(0, span - 1));
            end else begin
                beat.seq_num = win_base + SEQ_W'($urandom_range(0, WIN - 1));
            end
        end else if (pick < 86) begin
            beat.action = ACT_TMO;
            k = 0;
            while (!stored_valid[beat.seq_num] && k < SEQ_SPACE) begin
                beat.seq_num = beat.seq_num + 1'b1;
                k++;
            end
            if (!stored_valid[beat.seq_num]) beat.action = ACT_SEND;
        end else if (pick < 94) begin
            beat.action      = ACT_ACK;
            beat.checksum_ok = 1'($urandom_range(0, 1));
        end else if (pick < 97) begin
            beat.action = ACT_SEND;
        end else begin
            beat.action = ACT_RSVD;
        end
        return beat;
    endfunction

    task automatic offer_beat(input t_in_beat beat);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_responses.push_back(window_response(beat));
    endtask

    task automatic offer_op(input t_action act, input logic [SEQ_W-1:0] seq,
                            input logic ck, input logic [PAY_W-1:0] data);
        t_in_beat beat;
        beat.action      = act;
        beat.seq_num     = seq;
        beat.checksum_ok = ck;
        beat.payload     = data;
        offer_beat(beat);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_responses.size() != 0);
    endtask

    task automatic test_payload_extremes();
        offer_op(ACT_SEND, 3'd0, 1'b0, 64'h0);
        offer_op(ACT_SEND, 3'd7, 1'b1, '1);
        offer_op(ACT_TMO, 3'd1, 1'b0, {$urandom, $urandom});
        offer_op(ACT_TMO, 3'd0, 1'b1, '0);
    endtask

    task automatic test_window_fill();
        offer_op(ACT_SEND, 3'd5, 1'b1, 64'hA5A5_5A5A_0F0F_F0F0);
        offer_op(ACT_SEND, 3'd2, 1'b0, 64'h8000_0000_0000_0001);
        offer_op(ACT_SEND, 3'd0, 1'b1, 64'h1234_5678_9ABC_DEF0);
        offer_op(ACT_TMO, 3'd3, 1'b0, '0);
    endtask

    task automatic test_ack_drops();
        offer_op(ACT_ACK, 3'd2, 1'b0, '0);
        offer_op(ACT_ACK, 3'd4, 1'b1, '0);
        offer_op(ACT_ACK, 3'd7, 1'b1, '1);
    endtask

    task automatic test_ack_slide();
        offer_op(ACT_ACK, 3'd1, 1'b1, '0);
        offer_op(ACT_ACK, 3'd0, 1'b1, '0);
        offer_op(ACT_ACK, 3'd3, 1'b1, '0);
        offer_op(ACT_ACK, 3'd5, 1'b1, '0);
        offer_op(ACT_ACK, 3'd2, 1'b1, '0);
    endtask

    task automatic test_reserved_action();
        offer_op(ACT_RSVD, 3'd7, 1'b1, '1);
        offer_op(ACT_RSVD, 3'd0, 1'b0, '0);
    endtask

    task automatic test_back_pressure();
        int n;
        tx_idle_on = 1'b0;
        fork
            begin
                rx_holding <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_holding <= 1'b0;
            end
        join_none
        for (n = 0; n < 24; n++) offer_beat(draw_window_item());
        wait_drained();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        t_in_beat beat;
        int       counted;
        int       offered;
        counted = 0;
        offered = 0;
        while (counted < RANDOM_ITEMS) begin
            if (offered % 100 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on <= ($urandom_range(0, 3) != 0);
            end
            beat = draw_window_item();
            offer_beat(beat);
            offered++;
            if (beat.action != ACT_RSVD) counted++;
        end
    endtask

    always @(posedge i_clk) begin : rx_side
        int gap;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_gap  <= 0;
        end else if (rx_holding) begin
            i_stall <= 1'b1;
        end else if (rx_gap != 0) begin
            i_stall <= 1'b1;
            rx_gap  <= rx_gap - 1;
        end else if (o_valid === 1'b1 && !i_stall && rx_idle_on) begin
            gap = $urandom_range(0, 19);
            i_stall <= (gap != 0);
            rx_gap  <= (gap != 0) ? gap - 1 : 0;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("mismatch on %0s: expected %0h, got %0h", name, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out_beat want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_responses.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("result beat %0h arrived with nothing expected", o_data);
                end
            end else begin
                want = pending_responses.pop_front();
                compare_field("accepted", want.accepted, o_data.accepted);
                compare_field("tx_valid", want.tx_valid, o_data.tx_valid);
                compare_field("tx_seq", want.tx_seq, o_data.tx_seq);
                compare_field("tx_payload", want.tx_payload, o_data.tx_payload);
                compare_field("timer_start", want.timer_start, o_data.timer_start);
                compare_field("timer_stop", want.timer_stop, o_data.timer_stop);
                compare_field("timer_seq", want.timer_seq, o_data.timer_seq);
                compare_field("window_full", want.window_full, o_data.window_full);
                compare_field("window_base", want.window_base, o_data.window_base);
            end
        end
    end

    initial begin
        #(WATCHDOG_NS);
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_payload_extremes();
        test_window_fill();
        test_ack_drops();
        test_ack_slide();
        test_reserved_action();
        test_back_pressure();
        test_random_traffic();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_responses.size() != 0) begin
            mismatch_count++;
            $display("%0d result beats never arrived", pending_responses.size());
        end
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
